// ===== rtl/shs_pkg.sv =====
package shs_pkg;

    localparam int unsigned NUM_ROUNDS = 80;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hefcdab89;
    localparam logic [31:0] H2_INIT = 32'h98badcfe;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

    localparam logic [31:0] PAD_WORD    = 32'h80000000;
    localparam logic [31:0] LENGTH_WORD = 32'h000001a0;
    localparam logic [31:0] SOFT_RESET_FLAG = 32'h01000000;

    // Configuration register indexes.
    localparam logic [2:0] REG_NAZO_FIRST  = 3'd0;
    localparam logic [2:0] REG_NAZO_SECOND = 3'd1;
    localparam logic [2:0] REG_NAZO_LAST   = 3'd2;
    localparam logic [2:0] REG_MAC         = 3'd3;
    localparam logic [2:0] REG_SOFT_RESET  = 3'd4;
    localparam logic [2:0] REG_VFRAME      = 3'd5;
    localparam logic [2:0] REG_GX_STAT     = 3'd6;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] window_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
    } state_t;

    function automatic word_t swap32(input word_t v);
        swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic word_t rol1(input word_t v);
        rol1 = {v[30:0], v[31]};
    endfunction

    // One SHA-1 round with its round function and constant.
    function automatic state_t sha1_round(input state_t s, input word_t w,
                                          input int unsigned idx);
        word_t f;
        word_t k;
        state_t r;
        if (idx < 20) begin
            f = (s.b & s.c) | (~s.b & s.d);
            k = K0;
        end else if (idx < 40) begin
            f = s.b ^ s.c ^ s.d;
            k = K1;
        end else if (idx < 60) begin
            f = (s.b & s.c) | ((s.b | s.c) & s.d);
            k = K2;
        end else begin
            f = s.b ^ s.c ^ s.d;
            k = K3;
        end
        r.a = {s.a[26:0], s.a[31:27]} + f + s.e + k + w;
        r.b = s.a;
        r.c = {s.b[1:0], s.b[31:2]};
        r.d = s.c;
        r.e = s.d;
        sha1_round = r;
    endfunction

endpackage

// ===== rtl/sha1_seed_hash.sv =====
// Throughput: one beat per cycle; stage 0 builds the message block, stages 1 to 80
// each run one SHA-1 round and one schedule step, the output register adds and swaps.
// The whole pipeline advances together unless a valid output beat is held off;
// while it is held, every beat in flight waits in its stage.
// Reset (aresetn low, synchronous) clears all valid bits and configuration registers.
module sha1_seed_hash
    import shs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_timer_zero,
    input  logic [7:0]  s_vcount,
    input  logic [31:0] s_date_word,
    input  logic [31:0] s_time_word,
    input  logic [31:0] s_button_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_seed_value
);

    logic [63:0] nazo_first_reg;
    logic [63:0] nazo_second_reg;
    logic [31:0] nazo_last_reg;
    logic [47:0] mac_reg;
    logic        soft_reset_reg;
    logic [7:0]  vframe_reg;
    logic [7:0]  gx_stat_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nazo_first_reg  <= '0;
            nazo_second_reg <= '0;
            nazo_last_reg   <= '0;
            mac_reg         <= '0;
            soft_reset_reg  <= 1'b0;
            vframe_reg      <= '0;
            gx_stat_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NAZO_FIRST:  nazo_first_reg  <= cfg_data;
                REG_NAZO_SECOND: nazo_second_reg <= cfg_data;
                REG_NAZO_LAST:   nazo_last_reg   <= cfg_data[31:0];
                REG_MAC:         mac_reg         <= cfg_data[47:0];
                REG_SOFT_RESET:  soft_reset_reg  <= cfg_data[0];
                REG_VFRAME:      vframe_reg      <= cfg_data[7:0];
                REG_GX_STAT:     gx_stat_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Pipeline storage: stage 0 holds the block, stages 1..80 hold rounds.
    logic    [NUM_ROUNDS:0] vld_reg;
    state_t  st_reg  [NUM_ROUNDS:0];
    window_t win_reg [NUM_ROUNDS:0];
    logic    [63:0] seed_reg;
    logic           out_vld_reg;
    logic           advance;

    assign advance = !out_vld_reg || m_ready;
    assign s_ready = advance;

    // Message block assembly from registers and input fields.
    window_t blk;
    word_t   w6;
    always_comb begin
        w6 = {16'h0, mac_reg[15:0]};
        if (soft_reset_reg) begin
            w6 = w6 ^ SOFT_RESET_FLAG;
        end
        blk[0]  = nazo_first_reg[31:0];
        blk[1]  = nazo_first_reg[63:32];
        blk[2]  = nazo_second_reg[31:0];
        blk[3]  = nazo_second_reg[63:32];
        blk[4]  = nazo_last_reg;
        blk[5]  = swap32({8'h0, s_vcount, s_timer_zero});
        blk[6]  = w6;
        blk[7]  = mac_reg[47:16] ^ {vframe_reg, 24'h0} ^ {24'h0, gx_stat_reg};
        blk[8]  = s_date_word;
        blk[9]  = s_time_word;
        blk[10] = '0;
        blk[11] = '0;
        blk[12] = s_button_word;
        blk[13] = PAD_WORD;
        blk[14] = '0;
        blk[15] = LENGTH_WORD;
    end

    // Valid bits travel with the data; all stages move together.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            vld_reg     <= {vld_reg[NUM_ROUNDS-1:0], s_valid};
            out_vld_reg <= vld_reg[NUM_ROUNDS];
        end
    end

    // Stage 0 captures the block and the initial chaining state.
    always_ff @(posedge aclk) begin
        if (advance) begin
            win_reg[0] <= blk;
            st_reg[0]  <= '{a: H0_INIT, b: H1_INIT, c: H2_INIT, d: H3_INIT, e: H4_INIT};
        end
    end

    // Round stages: each consumes the oldest window word and appends the next.
    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
        window_t nxt_win;
        always_comb begin
            nxt_win[14:0] = win_reg[g-1][15:1];
            nxt_win[15]   = rol1(win_reg[g-1][13] ^ win_reg[g-1][8]
                                 ^ win_reg[g-1][2] ^ win_reg[g-1][0]);
        end
        always_ff @(posedge aclk) begin
            if (advance) begin
                st_reg[g]  <= sha1_round(st_reg[g-1], win_reg[g-1][0], g - 1);
                win_reg[g] <= nxt_win;
            end
        end
    end

    // Final add and byte swap into the output register.
    always_ff @(posedge aclk) begin
        if (advance) begin
            seed_reg <= {swap32(st_reg[NUM_ROUNDS].b + H1_INIT),
                         swap32(st_reg[NUM_ROUNDS].a + H0_INIT)};
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_seed_value = seed_reg;

endmodule

// ===== rtl/shs_checker.sv =====
module shs_checker
    import shs_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_seed_value
);

    // A stalled output beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_seed_value))
        else $error("output beat changed while stalled");

    // Input is always ready while the output is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output");

    // Stall propagates back: a blocked output blocks input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output blocked");

    // Nothing appears at the output right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind sha1_seed_hash shs_checker u_shs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_seed_value(m_seed_value)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import shs_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_timer_zero;
    logic [7:0]  s_vcount;
    logic [31:0] s_date_word;
    logic [31:0] s_time_word;
    logic [31:0] s_button_word;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_seed_value;

    sha1_seed_hash dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_timer_zero(s_timer_zero), .s_vcount(s_vcount),
        .s_date_word(s_date_word), .s_time_word(s_time_word),
        .s_button_word(s_button_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_seed_value(m_seed_value)
    );

    // Shadow copy of the configuration registers.
    logic [63:0] nazo_a;
    logic [63:0] nazo_b;
    logic [31:0] nazo_c;
    logic [47:0] mac_addr;
    logic        soft_rst;
    logic [7:0]  frame_val;
    logic [7:0]  gx_val;

    logic [63:0] seed_queue[$];
    int          error_count;
    int          beats_sent;
    int          seeds_checked;
    int          hold_cycles;
    bit          random_stall;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("Timeout waiting for seeds");
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [31:0] bswap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Builds the message block and runs the full 80-round compression.
    function automatic logic [63:0] compute_seed(input logic [15:0] tmr,
            input logic [7:0] vc, input logic [31:0] dw, input logic [31:0] tw,
            input logic [31:0] bw);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        w[0] = nazo_a[31:0];
        w[1] = nazo_a[63:32];
        w[2] = nazo_b[31:0];
        w[3] = nazo_b[63:32];
        w[4] = nazo_c;
        w[5] = bswap({8'h00, vc, tmr});
        w[6] = {16'h0000, mac_addr[15:0]} ^ (soft_rst ? SOFT_RESET_FLAG : 32'h0);
        w[7] = mac_addr[47:16] ^ {frame_val, 24'h000000} ^ {24'h000000, gx_val};
        w[8] = dw;
        w[9] = tw;
        w[10] = 32'h0;
        w[11] = 32'h0;
        w[12] = bw;
        w[13] = PAD_WORD;
        w[14] = 32'h0;
        w[15] = LENGTH_WORD;
        for (int i = 16; i < 80; i++)
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = H0_INIT; b = H1_INIT; c = H2_INIT; d = H3_INIT; e = H4_INIT;
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = K0;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = K1;
            end else if (i < 60) begin
                f = (b & c) | ((b | c) & d); k = K2;
            end else begin
                f = b ^ c ^ d; k = K3;
            end
            t = rotl(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rotl(b, 30); b = a; a = t;
        end
        return {bswap(b + H1_INIT), bswap(a + H0_INIT)};
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Writes one register; only done while the pipeline is empty.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_NAZO_FIRST:  nazo_a = val;
            REG_NAZO_SECOND: nazo_b = val;
            REG_NAZO_LAST:   nazo_c = val[31:0];
            REG_MAC:         mac_addr = val[47:0];
            REG_SOFT_RESET:  soft_rst = val[0];
            REG_VFRAME:      frame_val = val[7:0];
            REG_GX_STAT:     gx_val = val[7:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [63:0] na, input logic [63:0] nb,
            input logic [31:0] nc, input logic [47:0] mac, input logic sr,
            input logic [7:0] vf, input logic [7:0] gx);
        write_reg(REG_NAZO_FIRST, na);
        write_reg(REG_NAZO_SECOND, nb);
        write_reg(REG_NAZO_LAST, {$urandom, nc});
        write_reg(REG_MAC, {16'($urandom_range(0, 65535)), mac});
        write_reg(REG_SOFT_RESET, {$urandom, 31'h0, sr});
        write_reg(REG_VFRAME, {$urandom, 24'h0, vf});
        write_reg(REG_GX_STAT, {$urandom, 24'h0, gx});
    endtask

    // Offers one beat after an optional gap and waits for its acceptance.
    // Valid stays high after acceptance so beats can follow back to back.
    task automatic send_beat(input logic [15:0] tmr, input logic [7:0] vc,
            input logic [31:0] dw, input logic [31:0] tw, input logic [31:0] bw,
            input bit use_gap);
        int gap;
        gap = use_gap ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_timer_zero <= tmr;
        s_vcount <= vc;
        s_date_word <= dw;
        s_time_word <= tw;
        s_button_word <= bw;
        seed_queue.push_back(compute_seed(tmr, vc, dw, tw, bw));
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic send_random(input bit use_gap);
        send_beat(16'($urandom), 8'($urandom), $urandom, $urandom, $urandom, use_gap);
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (seed_queue.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Receiver: random stall per beat, or a long hold when requested.
    initial begin
        int wait_cycles;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                wait_cycles = random_stall ? $urandom_range(0, 6) : 0;
                if (wait_cycles > 0) begin
                    m_ready <= 1'b0;
                    repeat (wait_cycles) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    // Compares each accepted seed with the oldest prediction.
    initial begin
        logic [63:0] predicted;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (seed_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected seed %h", m_seed_value));
                end else begin
                    predicted = seed_queue.pop_front();
                    seeds_checked++;
                    if (m_seed_value !== predicted)
                        report_mismatch($sformatf("seed %h, predicted %h",
                            m_seed_value, predicted));
                end
            end
        end
    end

    task automatic test_reset_defaults();
        send_beat(16'h0, 8'h0, 32'h0, 32'h0, 32'h0, 0);
        send_beat(16'hffff, 8'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
        drain_pipeline();
    endtask

    task automatic test_field_extremes();
        set_config({64{1'b1}}, {64{1'b1}}, 32'hffffffff, {48{1'b1}}, 1'b1,
            8'hff, 8'hff);
        send_beat(16'h0, 8'h0, 32'h0, 32'h0, 32'h0, 0);
        send_beat(16'hffff, 8'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
        send_beat(16'h8001, 8'h80, 32'h80000001, 32'h55555555, 32'haaaaaaaa, 1);
        drain_pipeline();
        set_config(64'h0, 64'h0, 32'h0, 48'h0, 1'b0, 8'h0, 8'h0);
        send_beat(16'h1234, 8'h56, 32'h20240101, 32'h00123456, 32'h00002fff, 0);
        send_beat(16'hffff, 8'h0, 32'h0, 32'hffffffff, 32'h0, 0);
        drain_pipeline();
        // Write to an index beyond the register list must change nothing.
        write_reg(3'd7, {64{1'b1}});
        set_config(64'h0123456789abcdef, 64'hfedcba9876543210, 32'hdeadbeef,
            48'h0009bf123456, 1'b1, 8'h5a, 8'h06);
        for (int i = 0; i < 8; i++) send_random(1);
        drain_pipeline();
    endtask

    task automatic test_random_configs();
        for (int phase = 0; phase < 6; phase++) begin
            set_config({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                {$urandom, 16'($urandom)}, 1'($urandom), 8'($urandom), 8'($urandom));
            random_stall = (phase % 2 == 0);
            for (int i = 0; i < 120; i++) send_random(phase != 3);
            drain_pipeline();
        end
        random_stall = 1'b1;
    endtask

    task automatic test_backpressure();
        // Long receiver hold so the pipeline fills and stalls the input.
        hold_cycles = 300;
        for (int i = 0; i < 130; i++) send_random(0);
        drain_pipeline();
        for (int i = 0; i < 60; i++) send_random(1);
        drain_pipeline();
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; s_timer_zero = '0; s_vcount = '0;
        s_date_word = '0; s_time_word = '0; s_button_word = '0;
        nazo_a = '0; nazo_b = '0; nazo_c = '0; mac_addr = '0;
        soft_rst = 1'b0; frame_val = '0; gx_val = '0;
        error_count = 0; beats_sent = 0; seeds_checked = 0;
        hold_cycles = 0; random_stall = 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_field_extremes();
        test_random_configs();
        test_backpressure();
        $display("Sent %0d beats and checked %0d seeds across reset, extreme and random",
            beats_sent, seeds_checked);
        $display("register settings, with random gaps, stalls and a long output hold.");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/shs_pkg.sv
rtl/sha1_seed_hash.sv
rtl/shs_checker.sv
test/tb_top.sv
